FILE: hw/rtl/sctc_pkg.sv
// Shared types, constants and CRC step for the scratchpad CRC and temperature check.
package sctc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_UPPER_CLAMP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_CLAMP = 2'd1;

  localparam logic signed [15:0] UPPER_CLAMP_RST = 16'sd1250;
  localparam logic signed [15:0] LOWER_CLAMP_RST = -16'sd550;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] ALL_ONES_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ALL_FF  = 2'd1,
    STATUS_BAD_CRC = 2'd2
  } status_e;

  // Frame state handed to the result logic at the last byte
  typedef struct packed {
    logic [7:0] crc;
    logic [7:0] raw_low;
    logic [7:0] raw_high;
    logic       all_ones;
  } frame_t;

  // Reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b = b_in;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/sctc_result.sv
// Status decision, temperature scaling and clamping for a completed frame.
module sctc_result (
  input  sctc_pkg::frame_t   frame_i,
  input  logic [7:0]         check_byte_i,
  input  logic signed [15:0] upper_clamp_i,
  input  logic signed [15:0] lower_clamp_i,
  output sctc_pkg::status_e  status_o,
  output logic signed [15:0] temp_o
);

  logic signed [15:0] raw;
  logic signed [19:0] raw_ext;
  logic signed [19:0] prod;
  logic signed [19:0] biased;
  logic signed [19:0] quo;
  logic signed [15:0] scaled;
  logic signed [15:0] upper_applied;

  assign raw = $signed({frame_i.raw_high, frame_i.raw_low});
  assign raw_ext = 20'(raw);
  // times ten as shift-and-add
  assign prod = (raw_ext <<< 3) + (raw_ext <<< 1);
  // divide by sixteen, truncating toward zero
  assign biased = prod + (prod[19] ? 20'sd15 : 20'sd0);
  assign quo = biased >>> 4;
  assign scaled = quo[15:0];

  always_comb begin
    upper_applied = (scaled > upper_clamp_i) ? upper_clamp_i : scaled;
    priority if (frame_i.all_ones) begin
      status_o = sctc_pkg::STATUS_ALL_FF;
      temp_o = '0;
    end else if (frame_i.crc != check_byte_i) begin
      status_o = sctc_pkg::STATUS_BAD_CRC;
      temp_o = '0;
    end else begin
      status_o = sctc_pkg::STATUS_OK;
      // lower limit last, so it wins when the limits cross
      temp_o = (upper_applied < lower_clamp_i) ? lower_clamp_i : upper_applied;
    end
  end

endmodule

FILE: hw/rtl/scratchpad_crc_temp_check.sv
// A frame's result word enters the output register the cycle after its last byte is accepted.
// Throughput: one byte per cycle unless stalled; CRC step and result logic are combinational.
// Input stalls only for a last byte while an earlier result word is still held downstream.
// Reset clears the byte count and CRC, sets the all-0xFF flag and loads the clamp limits (1250, -550).
// A start flag on any byte restarts the frame with that byte as byte zero.
module scratchpad_crc_temp_check #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     byte_value_i,
  input  logic                           start_of_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic signed [15:0]             temperature_tenths_o,
  input  logic                           cfg_we_i,
  input  logic [sctc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sctc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0]    pos_q, pos_d, pos_eff;
  logic [7:0]         crc_q, crc_d, crc_eff;
  logic               all_ones_q, all_ones_d, all_ones_eff;
  logic [7:0]         raw_low_q, raw_low_d, raw_high_q, raw_high_d;
  logic signed [15:0] upper_q, lower_q;
  logic               out_valid_q, out_valid_d;
  sctc_pkg::status_e  status_q, status_d;
  logic signed [15:0] temp_q, temp_d;

  logic               in_accept, out_accept, is_last;
  sctc_pkg::frame_t   frame;
  sctc_pkg::status_e  res_status;
  logic signed [15:0] res_temp;

  assign pos_eff = start_of_frame_i ? '0 : pos_q;
  assign crc_eff = start_of_frame_i ? '0 : crc_q;
  assign all_ones_eff = (start_of_frame_i | all_ones_q) & (byte_value_i == sctc_pkg::ALL_ONES_BYTE);
  assign is_last = (pos_eff == LastPos);

  // hold off a last byte only while the output word cannot move
  assign in_stall_o = out_valid_q & out_stall_i & is_last;
  assign in_accept = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_q & ~out_stall_i;

  assign frame.crc = crc_eff;
  assign frame.raw_low = raw_low_q;
  assign frame.raw_high = raw_high_q;
  assign frame.all_ones = all_ones_eff;

  sctc_result u_result (
    .frame_i       (frame),
    .check_byte_i  (byte_value_i),
    .upper_clamp_i (upper_q),
    .lower_clamp_i (lower_q),
    .status_o      (res_status),
    .temp_o        (res_temp)
  );

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    all_ones_d = all_ones_q;
    raw_low_d = raw_low_q;
    raw_high_d = raw_high_q;
    out_valid_d = out_valid_q & ~out_accept;
    status_d = status_q;
    temp_d = temp_q;
    if (in_accept) begin
      if (pos_eff == '0) begin
        raw_low_d = byte_value_i;
      end
      if (pos_eff == PosW'(1)) begin
        raw_high_d = byte_value_i;
      end
      if (is_last) begin
        pos_d = '0;
        crc_d = '0;
        all_ones_d = 1'b1;
        out_valid_d = 1'b1;
        status_d = res_status;
        temp_d = res_temp;
      end else begin
        pos_d = pos_eff + PosW'(1);
        crc_d = sctc_pkg::crc_byte(crc_eff, byte_value_i);
        all_ones_d = all_ones_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      all_ones_q <= 1'b1;
      raw_low_q <= '0;
      raw_high_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      all_ones_q <= all_ones_d;
      raw_low_q <= raw_low_d;
      raw_high_q <= raw_high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    temp_q <= temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= sctc_pkg::UPPER_CLAMP_RST;
      lower_q <= sctc_pkg::LOWER_CLAMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sctc_pkg::CFG_UPPER_CLAMP: upper_q <= $signed(cfg_data_i);
        sctc_pkg::CFG_LOWER_CLAMP: lower_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign temperature_tenths_o = temp_q;

`ifndef SYNTH
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position beyond frame");

  a_error_temp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sctc_pkg::STATUS_OK |-> temperature_tenths_o == 16'sd0)
    else $error("temperature not zero on error status");

  a_ok_above_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sctc_pkg::STATUS_OK |-> temperature_tenths_o >= lower_q)
    else $error("temperature below lower clamp");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_last |=> pos_q == '0 && all_ones_q && crc_q == 8'h00 && out_valid_q)
    else $error("frame not rearmed after last byte");
`endif

endmodule

FILE: tb/sv/tb_scratchpad_crc_temp_check.sv
// Testbench for the scratchpad CRC and temperature check: framed byte traffic and result checks.
module tb_scratchpad_crc_temp_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN = 9;

  localparam logic [sctc_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [sctc_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_ALL_FF} frame_kind_e;
  typedef enum int {RX_READY, RX_RANDOM, RX_PERIODIC, RX_CONGESTED} rx_mode_e;

  typedef struct {
    sctc_pkg::status_e  status;
    logic signed [15:0] tenths;
  } reading_t;

  class temp_frame_scoreboard;
    logic signed [15:0] upper_limit;
    logic signed [15:0] lower_limit;
    int unsigned        pos;
    logic [7:0]         crc;
    logic               only_ff;
    logic [7:0]         low_byte;
    logic [7:0]         high_byte;
    reading_t           expected_readings[$];
    int unsigned        errors;
    int unsigned        bytes_seen;
    int unsigned        readings_checked;
    int unsigned        status_count[3];

    function new();
      upper_limit = sctc_pkg::UPPER_CLAMP_RST;
      lower_limit = sctc_pkg::LOWER_CLAMP_RST;
      low_byte = 8'h00;
      high_byte = 8'h00;
      restart();
    endfunction

    static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
        if (acc[0] ^ b[i]) acc = (acc >> 1) ^ sctc_pkg::CRC_POLY;
        else acc = acc >> 1;
      end
      return acc;
    endfunction

    function void restart();
      pos = 0;
      crc = 8'h00;
      only_ff = 1'b1;
    endfunction

    function void set_limit(logic [sctc_pkg::CfgIdxW-1:0] idx,
                            logic [sctc_pkg::CfgDataW-1:0] data);
      case (idx)
        sctc_pkg::CFG_UPPER_CLAMP: upper_limit = data;
        sctc_pkg::CFG_LOWER_CLAMP: lower_limit = data;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      reading_t r;
      int       raw;
      int       tenths;
      bytes_seen++;
      if (sof) restart();
      if (pos == 0) low_byte = b;
      else if (pos == 1) high_byte = b;
      if (b != sctc_pkg::ALL_ONES_BYTE) only_ff = 1'b0;
      if (pos < FRAME_LEN - 1) begin
        crc = crc_step(crc, b);
        pos++;
        return;
      end
      r.tenths = 16'sd0;
      if (only_ff) begin
        r.status = sctc_pkg::STATUS_ALL_FF;
      end else if (crc != b) begin
        r.status = sctc_pkg::STATUS_BAD_CRC;
      end else begin
        raw = $signed({high_byte, low_byte});
        tenths = (raw * 10) / 16;
        // lower limit goes last so it wins when the limits cross
        if (tenths > upper_limit) tenths = upper_limit;
        if (tenths < lower_limit) tenths = lower_limit;
        r.status = sctc_pkg::STATUS_OK;
        r.tenths = 16'(tenths);
      end
      status_count[r.status]++;
      expected_readings.push_back(r);
      restart();
    endfunction

    function void check_reading(logic [1:0] st, logic signed [15:0] t);
      reading_t r;
      if (expected_readings.size() == 0) begin
        $display("%0t: result with none expected: status %0d temperature %0d", $time, st, t);
        errors++;
        return;
      end
      r = expected_readings.pop_front();
      readings_checked++;
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (t !== r.tenths) begin
        $display("%0t: temperature expected %0d actual %0d", $time, r.tenths, t);
        errors++;
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [7:0]                          byte_value_i = 8'h00;
  logic                                start_of_frame_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [1:0]                          status_o;
  logic signed [15:0]                  temperature_tenths_o;
  logic                                cfg_we_i = 1'b0;
  logic [sctc_pkg::CfgIdxW-1:0]        cfg_index_i = sctc_pkg::CFG_UPPER_CLAMP;
  logic [sctc_pkg::CfgDataW-1:0]       cfg_data_i = '0;

  temp_frame_scoreboard sb;
  int unsigned          burst_left;
  logic                 gaps_on;
  int unsigned          limit_sets;
  int unsigned          rx_tick;
  rx_mode_e             rx_mode = RX_READY;

  scratchpad_crc_temp_check #(
    .FRAME_BYTES(FRAME_LEN)
  ) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .byte_value_i        (byte_value_i),
    .start_of_frame_i    (start_of_frame_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .temperature_tenths_o(temperature_tenths_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: switch stall pattern every so often
  always @(posedge clk_i) begin
    if (rx_tick % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    rx_tick++;
    case (rx_mode)
      RX_READY:    out_stall_i <= 1'b0;
      RX_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall_i <= ((rx_tick % 16) < 9);
      default:     out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_reading(status_o, temperature_tenths_o);
      if (in_valid_i && !in_stall_o) sb.note_byte(byte_value_i, start_of_frame_i);
    end
  end

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 7) == 0) ? sctc_pkg::ALL_ONES_BYTE : 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_raw();
    int unsigned sel;
    int          sensor;
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (sel < 4) begin
      // sensor range in sixteenths with some margin past both ends
      sensor = int'($urandom_range(0, 3600)) - 1200;
      return 16'(sensor);
    end
    return 16'($urandom);
  endfunction

  task automatic send_byte(logic [7:0] b, logic sof);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    start_of_frame_i <= sof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_frame(frame_kind_e kind, logic [15:0] raw, logic sof_first);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (kind == FRAME_ALL_FF) fb[i] = sctc_pkg::ALL_ONES_BYTE;
      else if (i == 0) fb[i] = raw[7:0];
      else if (i == 1) fb[i] = raw[15:8];
      else if (i < FRAME_LEN - 1) fb[i] = rand_byte();
      else if (kind == FRAME_GOOD) fb[i] = crc;
      else fb[i] = crc ^ 8'($urandom_range(1, 255));
      crc = temp_frame_scoreboard::crc_step(crc, fb[i]);
    end
    for (int i = 0; i < FRAME_LEN; i++) send_byte(fb[i], (i == 0) ? sof_first : 1'b0);
  endtask

  task automatic send_partial(int unsigned n);
    for (int i = 0; i < n; i++) send_byte(rand_byte(), i == 0);
  endtask

  task automatic send_noise(int unsigned n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // Hold off until every expected result is out, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sctc_pkg::CfgIdxW-1:0] idx,
                           logic [sctc_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_limit(idx, data);
  endtask

  task automatic set_limits(logic [15:0] upper, logic [15:0] lower);
    drain();
    write_reg(sctc_pkg::CFG_UPPER_CLAMP, upper);
    write_reg(sctc_pkg::CFG_LOWER_CLAMP, lower);
    // spare indexes must leave both limits alone
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'($urandom));
    cfg_we_i <= 1'b0;
    limit_sets++;
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned choice;
    logic        need_sof;
    int          lim_hi;
    int          lim_lo;
    sb = new();
    gaps_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: restart mid-frame, extreme raw values, priority of all-0xFF, wrap without flag
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    send_frame(FRAME_GOOD, 16'h8000, 1'b1);
    send_frame(FRAME_ALL_FF, 16'hFFFF, 1'b0);
    send_frame(FRAME_BAD_CRC, 16'h7FFF, 1'b1);

    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: begin lim_hi = 20479;  lim_lo = -20480; end
        2: begin lim_hi = -20480; lim_lo = 20479;  end
        3: begin lim_hi = 100;    lim_lo = -100;   end
        4: begin lim_hi = -100;   lim_lo = 300;    end
        5: begin
          lim_hi = int'($urandom_range(0, 40959)) - 20480;
          lim_lo = int'($urandom_range(0, 40959)) - 20480;
        end
        default: begin lim_hi = 1250; lim_lo = -550; end
      endcase
      set_limits(16'(lim_hi), 16'(lim_lo));
      gaps_on = ($urandom_range(0, 3) != 0);
      need_sof = 1'b0;
      phase_start = sb.bytes_seen;
      while (sb.bytes_seen - phase_start < 66) begin
        choice = $urandom_range(0, 19);
        if (choice < 12) begin
          send_frame(FRAME_GOOD, pick_raw(), need_sof | ($urandom_range(0, 1) == 1));
          need_sof = 1'b0;
        end else if (choice < 14) begin
          send_frame(FRAME_BAD_CRC, pick_raw(), need_sof | ($urandom_range(0, 1) == 1));
          need_sof = 1'b0;
        end else if (choice < 16) begin
          send_frame(FRAME_ALL_FF, 16'hFFFF, need_sof | ($urandom_range(0, 1) == 1));
          need_sof = 1'b0;
        end else if (choice < 18) begin
          send_partial($urandom_range(1, FRAME_LEN - 1));
          need_sof = 1'b1;
        end else begin
          send_noise($urandom_range(1, 12));
          need_sof = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d bytes sent, %0d results checked over %0d limit settings",
             sb.bytes_seen, sb.readings_checked, limit_sets + 1);
    $display("summary: %0d ok, %0d all-0xFF, %0d CRC mismatch",
             sb.status_count[sctc_pkg::STATUS_OK], sb.status_count[sctc_pkg::STATUS_ALL_FF],
             sb.status_count[sctc_pkg::STATUS_BAD_CRC]);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout waiting for traffic to complete");
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sctc_pkg.sv
hw/rtl/sctc_result.sv
hw/rtl/scratchpad_crc_temp_check.sv
tb/sv/tb_scratchpad_crc_temp_check.sv
